// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTP frame jitter buffer RTL.
// Depends on nothing; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RFJB_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("rfjb assertion failed");
`define RFJB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rfjb assertion failed");
`else
`define RFJB_ASSERT(lbl, clk, rstn, prop)
`define RFJB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== src/rfjb_pkg.sv =====
// Package of the RTP frame jitter buffer: sizes, codes, command and status types.
// Depends on nothing; used by every other file except assert_macros.svh.
package rfjb_pkg;

    localparam int MAX_FRAMES  = 16;
    localparam int MAX_PKTS    = 32;
    localparam int HANDLE_BITS = 10;
    localparam int FIDX_W      = $clog2(MAX_FRAMES);
    localparam int SIDX_W      = $clog2(MAX_PKTS);
    localparam int CNT_W       = SIDX_W + 1;
    localparam int SLOT_AW     = FIDX_W + SIDX_W;
    localparam int SLOT_DEPTH  = MAX_FRAMES * MAX_PKTS;
    localparam int STAMP_W     = 32;
    localparam int SEQ_W       = 16;
    localparam int AGE_W       = 16;
    localparam int EXP_W       = 16;
    localparam logic [EXP_W-1:0] EXPIRY_RESET = 16'd200;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_TICK   = 2'd1,
        OP_QUERY  = 2'd2,
        OP_POP    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_NEW        = 3'd0,
        ST_ADDED      = 3'd1,
        ST_DUP        = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_PKTS_FULL  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        RES_STATUS,
        RES_AVAIL0,
        RES_AVAIL1,
        RES_PKT,
        RES_POP_EMPTY
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK,
        S_INS_FIND,
        S_DUP_RD,
        S_DUP_CMP,
        S_INS_WR,
        S_RANK_INIT,
        S_RANK,
        S_WALK,
        S_DECIDE,
        S_GATHER_RD,
        S_GATHER_WR,
        S_EMIT,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic latch;
        logic age_tick;
        logic ins_select;
        logic slot_rd;
        logic dup_check;
        logic ins_commit;
        logic rank_init;
        logic rank_step;
        logic walk_step;
        logic gather_init;
        logic gather_step;
        logic emit;
        logic emit_adv;
        logic frame_drop;
        t_res res;
    } t_cmd;

    typedef struct packed {
        logic match_hit;
        logic match_cnt_zero;
        logic free_hit;
        logic dup_hit;
        logic k_last;
        logic j_last;
        logic p_last;
        logic oldest_ok;
        logic out_free;
        logic pres_cur;
        logic pkt_last;
    } t_stat;

endpackage

// ===== src/rfjb_pkt_if.sv =====
// Input channel of the jitter buffer: one packet descriptor or command per transaction.
// Depends on rfjb_pkg.
interface rfjb_pkt_if;
    import rfjb_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [1:0]             operation;
    logic [STAMP_W-1:0]     rtp_stamp;
    logic [SEQ_W-1:0]       seq_number;
    logic                   marker_bit;
    logic [HANDLE_BITS-1:0] packet_handle;

    modport source (output valid, operation, rtp_stamp, seq_number, marker_bit,
                    packet_handle, input ready);
    modport sink (input valid, operation, rtp_stamp, seq_number, marker_bit,
                  packet_handle, output ready);
endinterface

// ===== src/rfjb_res_if.sv =====
// Result channel of the jitter buffer: one result item per transaction.
// Depends on rfjb_pkg.
interface rfjb_res_if;
    import rfjb_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [2:0]             status;
    logic                   available;
    logic [STAMP_W-1:0]     frame_stamp_out;
    logic [HANDLE_BITS-1:0] handle_out;
    logic [SEQ_W-1:0]       seq_out;
    logic                   last_out;

    modport source (output valid, status, available, frame_stamp_out, handle_out,
                    seq_out, last_out, input ready);
    modport sink (input valid, status, available, frame_stamp_out, handle_out,
                  seq_out, last_out, output ready);
endinterface

// ===== src/rfjb_ctrl.sv =====
// Sequencer of the jitter buffer: walks each operation through its steps.
// Depends on rfjb_pkg; drives the datapath by t_cmd, reads t_stat back.
module rfjb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_operation,
    output logic           o_in_ready,
    input  rfjb_pkg::t_stat i_stat,
    output rfjb_pkg::t_cmd  o_cmd
);
    import rfjb_pkg::*;

    t_state r_state, n_state;
    t_res   r_res, n_res;
    logic   r_pop, n_pop;
    t_op    op;

    assign op = t_op'(i_operation);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_res   <= RES_STATUS;
            r_pop   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
            r_pop   <= n_pop;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        n_pop   = r_pop;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (op)
                        OP_INSERT: n_state = S_INS_FIND;
                        OP_TICK:   n_state = S_TICK;
                        OP_QUERY: begin
                            n_pop   = 1'b0;
                            n_state = S_RANK_INIT;
                        end
                        OP_POP: begin
                            n_pop   = 1'b1;
                            n_state = S_RANK_INIT;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_TICK: n_state = S_IDLE;
            S_INS_FIND: begin
                if (i_stat.match_hit) begin
                    n_state = i_stat.match_cnt_zero ? S_INS_WR : S_DUP_RD;
                end else if (i_stat.free_hit) begin
                    n_state = S_INS_WR;
                end else begin
                    n_res   = RES_STATUS;
                    n_state = S_RESULT;
                end
            end
            S_DUP_RD: n_state = S_DUP_CMP;
            S_DUP_CMP: begin
                if (i_stat.dup_hit) begin
                    n_res   = RES_STATUS;
                    n_state = S_RESULT;
                end else if (i_stat.k_last) begin
                    n_state = S_INS_WR;
                end else begin
                    n_state = S_DUP_RD;
                end
            end
            S_INS_WR: begin
                n_res   = RES_STATUS;
                n_state = S_RESULT;
            end
            S_RANK_INIT: n_state = S_RANK;
            S_RANK: begin
                if (i_stat.j_last) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (i_stat.p_last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_stat.oldest_ok) begin
                    n_res   = RES_AVAIL0;
                    n_state = S_RESULT;
                end else if (!r_pop) begin
                    n_res   = RES_AVAIL1;
                    n_state = S_RESULT;
                end else begin
                    n_state = S_GATHER_RD;
                end
            end
            S_GATHER_RD: n_state = S_GATHER_WR;
            S_GATHER_WR: n_state = i_stat.k_last ? S_EMIT : S_GATHER_RD;
            S_EMIT: begin
                if (i_stat.out_free && (!i_stat.pres_cur || i_stat.pkt_last)) begin
                    n_state = S_IDLE;
                end
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_cmd.res  = RES_STATUS;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            S_TICK:      o_cmd.age_tick    = 1'b1;
            S_INS_FIND:  o_cmd.ins_select  = 1'b1;
            S_DUP_RD:    o_cmd.slot_rd     = 1'b1;
            S_DUP_CMP:   o_cmd.dup_check   = 1'b1;
            S_INS_WR:    o_cmd.ins_commit  = 1'b1;
            S_RANK_INIT: o_cmd.rank_init   = 1'b1;
            S_RANK:      o_cmd.rank_step   = 1'b1;
            S_WALK:      o_cmd.walk_step   = 1'b1;
            S_DECIDE:    o_cmd.gather_init = 1'b1;
            S_GATHER_RD: o_cmd.slot_rd     = 1'b1;
            S_GATHER_WR: o_cmd.gather_step = 1'b1;
            S_EMIT: begin
                o_cmd.emit       = i_stat.out_free;
                o_cmd.emit_adv   = i_stat.out_free;
                o_cmd.res        = i_stat.pres_cur ? RES_PKT : RES_POP_EMPTY;
                o_cmd.frame_drop = i_stat.out_free &&
                                   (!i_stat.pres_cur || i_stat.pkt_last);
            end
            S_RESULT: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.res  = r_res;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== src/rfjb_dpath.sv =====
// Datapath of the jitter buffer: frame table, packet slot memory, expiry walk,
// pop reorder buffer and the result register. Depends on rfjb_pkg, assert_macros.svh.
`include "assert_macros.svh"
module rfjb_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rfjb_pkg::t_cmd                  i_cmd,
    output rfjb_pkg::t_stat                 o_stat,
    input  logic                            i_cfg_we,
    input  logic [rfjb_pkg::EXP_W-1:0]      i_cfg_data,
    input  logic [rfjb_pkg::STAMP_W-1:0]    i_rtp_stamp,
    input  logic [rfjb_pkg::SEQ_W-1:0]      i_seq_number,
    input  logic                            i_marker_bit,
    input  logic [rfjb_pkg::HANDLE_BITS-1:0] i_packet_handle,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [2:0]                      o_status,
    output logic                            o_available,
    output logic [rfjb_pkg::STAMP_W-1:0]    o_frame_stamp_out,
    output logic [rfjb_pkg::HANDLE_BITS-1:0] o_handle_out,
    output logic [rfjb_pkg::SEQ_W-1:0]      o_seq_out,
    output logic                            o_last_out
);
    import rfjb_pkg::*;

    // latched item and configuration
    logic [STAMP_W-1:0]     r_in_stamp;
    logic [SEQ_W-1:0]       r_in_seq;
    logic                   r_in_mk;
    logic [HANDLE_BITS-1:0] r_in_handle;
    logic [EXP_W-1:0]       r_expiry;

    // frame table
    logic [MAX_FRAMES-1:0]  r_used;
    logic [STAMP_W-1:0]     r_stamp    [MAX_FRAMES];
    logic [AGE_W-1:0]       r_age      [MAX_FRAMES];
    logic [SEQ_W-1:0]       r_first    [MAX_FRAMES];
    logic [SEQ_W-1:0]       r_marker   [MAX_FRAMES];
    logic [MAX_FRAMES-1:0]  r_marked;
    logic [MAX_FRAMES-1:0]  r_complete;
    logic [CNT_W-1:0]       r_count    [MAX_FRAMES];

    // packet slot memory
    logic [SEQ_W-1:0]       mem_seq    [SLOT_DEPTH];
    logic [HANDLE_BITS-1:0] mem_handle [SLOT_DEPTH];
    logic [SEQ_W-1:0]       r_rd_seq;
    logic [HANDLE_BITS-1:0] r_rd_handle;

    // walk and pop state
    logic [FIDX_W-1:0]      r_rank     [MAX_FRAMES];
    logic [MAX_FRAMES-1:0]  r_ranked;
    logic [FIDX_W-1:0]      r_frame;
    logic [CNT_W-1:0]       r_k;
    logic [FIDX_W-1:0]      r_j;
    logic [FIDX_W-1:0]      r_p;
    logic [SIDX_W-1:0]      r_e;
    logic                   r_found;
    t_status                r_status;
    logic [MAX_PKTS-1:0]    r_pres;
    logic [HANDLE_BITS-1:0] r_harr     [MAX_PKTS];
    logic                   r_out_valid;

    // combinational
    logic                   match_hit, free_hit;
    logic [FIDX_W-1:0]      match_idx, free_idx;
    logic [FIDX_W-1:0]      fsel;
    logic [STAMP_W-1:0]     stamp_sel;
    logic [CNT_W-1:0]       cur_count;
    logic                   cnt_full;
    logic [SEQ_W-1:0]       first_new, marker_new, need;
    logic                   marked_new;
    logic [CNT_W-1:0]       cnt_new;
    logic                   sel_hit, next_c, expired;
    logic [FIDX_W-1:0]      sel_idx;
    logic [FIDX_W:0]        p_next;
    logic [EXP_W-1:0]       limit;
    logic [SEQ_W-1:0]       offset;
    logic                   out_free, pkt_last;
    logic [SLOT_AW-1:0]     rd_addr, wr_addr;

    always_comb begin
        match_hit = 1'b0;
        match_idx = '0;
        free_hit  = 1'b0;
        free_idx  = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
            if (r_used[i] && (r_stamp[i] == r_in_stamp)) begin
                match_hit = 1'b1;
                match_idx = FIDX_W'(i);
            end
            if (!r_used[i]) begin
                free_hit = 1'b1;
                free_idx = FIDX_W'(i);
            end
        end
    end

    assign fsel      = i_cmd.rank_step ? r_j : r_frame;
    assign stamp_sel = r_stamp[fsel];
    assign cur_count = r_count[r_frame];
    assign cnt_full  = (cur_count >= CNT_W'(MAX_PKTS));
    assign rd_addr   = {r_frame, r_k[SIDX_W-1:0]};
    assign wr_addr   = {r_frame, cur_count[SIDX_W-1:0]};

    // frame update on insert commit
    always_comb begin
        first_new  = ((cur_count == '0) || (r_in_seq < r_first[r_frame])) ?
                     r_in_seq : r_first[r_frame];
        marked_new = r_marked[r_frame] | r_in_mk;
        marker_new = r_in_mk ? r_in_seq : r_marker[r_frame];
        cnt_new    = cur_count + 1'b1;
        need       = marker_new - first_new + 1'b1;
    end

    // expiry walk: frame at rank p, completeness of the frame at rank p+1
    assign p_next = {1'b0, r_p} + 1'b1;
    always_comb begin
        sel_hit = 1'b0;
        sel_idx = '0;
        next_c  = 1'b0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (r_ranked[i] && (r_rank[i] == r_p)) begin
                sel_hit = 1'b1;
                sel_idx = FIDX_W'(i);
            end
            if (r_ranked[i] && r_complete[i] && ({1'b0, r_rank[i]} == p_next)) begin
                next_c = 1'b1;
            end
        end
        limit   = next_c ? {1'b0, r_expiry[EXP_W-1:1]} : r_expiry;
        expired = (r_age[sel_idx] > limit);
    end

    assign offset   = r_rd_seq - r_first[r_frame];
    assign out_free = !r_out_valid || i_out_ready;
    assign pkt_last = (&r_e) || !r_pres[r_e + 1'b1];

    always_comb begin
        o_stat                = '0;
        o_stat.match_hit      = match_hit;
        o_stat.match_cnt_zero = (r_count[match_idx] == '0);
        o_stat.free_hit       = free_hit;
        o_stat.dup_hit        = (r_rd_seq == r_in_seq);
        o_stat.k_last         = ((r_k + 1'b1) == cur_count);
        o_stat.j_last         = &r_j;
        o_stat.p_last         = &r_p;
        o_stat.oldest_ok      = r_found && r_complete[r_frame];
        o_stat.out_free       = out_free;
        o_stat.pres_cur       = r_pres[r_e];
        o_stat.pkt_last       = pkt_last;
    end

    // item latch and configuration
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_in_stamp  <= i_rtp_stamp;
            r_in_seq    <= i_seq_number;
            r_in_mk     <= i_marker_bit;
            r_in_handle <= i_packet_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expiry <= EXPIRY_RESET;
        end else if (i_cfg_we) begin
            r_expiry <= i_cfg_data;
        end
    end

    // frame table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            for (int i = 0; i < MAX_FRAMES; i++) begin
                if (i_cmd.age_tick && r_used[i] && (r_age[i] != '1)) begin
                    r_age[i] <= r_age[i] + 1'b1;
                end
            end
            if (i_cmd.ins_select && !match_hit && free_hit) begin
                r_used[free_idx]     <= 1'b1;
                r_stamp[free_idx]    <= r_in_stamp;
                r_age[free_idx]      <= '0;
                r_first[free_idx]    <= '0;
                r_marker[free_idx]   <= '0;
                r_marked[free_idx]   <= 1'b0;
                r_complete[free_idx] <= 1'b0;
                r_count[free_idx]    <= '0;
            end
            if (i_cmd.ins_commit && !cnt_full) begin
                r_first[r_frame]  <= first_new;
                r_count[r_frame]  <= cnt_new;
                r_marked[r_frame] <= marked_new;
                r_marker[r_frame] <= marker_new;
                if (marked_new && !r_complete[r_frame] &&
                    (need == {{(SEQ_W-CNT_W){1'b0}}, cnt_new})) begin
                    r_complete[r_frame] <= 1'b1;
                end
            end
            // drop a stale frame
            if (i_cmd.walk_step && sel_hit && expired) begin
                r_used[sel_idx] <= 1'b0;
            end
            if (i_cmd.frame_drop) begin
                r_used[r_frame] <= 1'b0;
            end
        end
    end

    // slot memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_commit && !cnt_full) begin
            mem_seq[wr_addr]    <= r_in_seq;
            mem_handle[wr_addr] <= r_in_handle;
        end
        if (i_cmd.slot_rd) begin
            r_rd_seq    <= mem_seq[rd_addr];
            r_rd_handle <= mem_handle[rd_addr];
        end
    end

    // ranks: count used frames with a lower timestamp, one frame per cycle
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (i_cmd.rank_init) begin
                r_rank[i] <= '0;
            end else if (i_cmd.rank_step && r_ranked[r_j] && (stamp_sel < r_stamp[i])) begin
                r_rank[i] <= r_rank[i] + 1'b1;
            end
        end
    end

    // reorder buffer of the popped frame, indexed by offset from first sequence
    always_ff @(posedge i_clk) begin
        if (i_cmd.gather_step && (offset[SEQ_W-1:SIDX_W] == '0)) begin
            r_harr[offset[SIDX_W-1:0]] <= r_rd_handle;
        end
    end

    // counters and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ranked <= '0;
            r_frame  <= '0;
            r_k      <= '0;
            r_j      <= '0;
            r_p      <= '0;
            r_e      <= '0;
            r_found  <= 1'b0;
            r_status <= ST_NEW;
            r_pres   <= '0;
        end else begin
            if (i_cmd.ins_select) begin
                r_k <= '0;
                if (match_hit) begin
                    r_frame  <= match_idx;
                    r_status <= ST_ADDED;
                end else if (free_hit) begin
                    r_frame  <= free_idx;
                    r_status <= ST_NEW;
                end else begin
                    r_status <= ST_TABLE_FULL;
                end
            end
            if (i_cmd.dup_check) begin
                if (r_rd_seq == r_in_seq) begin
                    r_status <= ST_DUP;
                end
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.ins_commit && cnt_full) begin
                r_status <= ST_PKTS_FULL;
            end
            if (i_cmd.rank_init) begin
                r_ranked <= r_used;
                r_j      <= '0;
                r_p      <= '0;
                r_found  <= 1'b0;
            end
            if (i_cmd.rank_step) begin
                r_j <= r_j + 1'b1;
            end
            if (i_cmd.walk_step) begin
                r_p <= r_p + 1'b1;
                if (sel_hit && !expired && !r_found) begin
                    r_found <= 1'b1;
                    r_frame <= sel_idx;
                end
            end
            if (i_cmd.gather_init) begin
                r_pres <= '0;
                r_k    <= '0;
                r_e    <= '0;
            end
            if (i_cmd.gather_step) begin
                r_k <= r_k + 1'b1;
                if (offset[SEQ_W-1:SIDX_W] == '0) begin
                    r_pres[offset[SIDX_W-1:0]] <= 1'b1;
                end
            end
            if (i_cmd.emit_adv) begin
                r_e <= r_e + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status          <= (i_cmd.res == RES_STATUS) ? r_status : 3'(ST_NEW);
            o_available       <= (i_cmd.res == RES_AVAIL1) || (i_cmd.res == RES_PKT) ||
                                 (i_cmd.res == RES_POP_EMPTY);
            o_frame_stamp_out <= ((i_cmd.res == RES_PKT) || (i_cmd.res == RES_POP_EMPTY)) ?
                                 r_stamp[r_frame] : '0;
            o_handle_out      <= (i_cmd.res == RES_PKT) ? r_harr[r_e] : '0;
            o_seq_out         <= (i_cmd.res == RES_PKT) ?
                                 (r_first[r_frame] + {{(SEQ_W-SIDX_W){1'b0}}, r_e}) : '0;
            o_last_out        <= (i_cmd.res == RES_PKT) ? pkt_last : 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;

    `RFJB_ASSERT(a_commit_used, i_clk, i_rst_n, i_cmd.ins_commit |-> r_used[r_frame])
    `RFJB_ASSERT(a_rd_in_range, i_clk, i_rst_n, i_cmd.slot_rd |-> (r_k < cur_count))
    `RFJB_ASSERT(a_drop_found, i_clk, i_rst_n, i_cmd.frame_drop |-> r_found)
    `RFJB_ASSERT_NEXT(a_drop_clears, i_clk, i_rst_n, i_cmd.frame_drop, !r_used[r_frame])

endmodule

// ===== src/rtp_frame_jitter_buffer_unit.sv =====
// Top level of the RTP frame jitter buffer: sequencer plus datapath.
// Depends on rfjb_pkg, rfjb_pkt_if, rfjb_res_if, rfjb_ctrl, rfjb_dpath.
//
//   channel   direction  transaction
//   i_pkt     in         operation + packet descriptor (insert/tick/query/pop)
//   o_res     out        status/available/frame stamp/handle/seq/last
//   i_cfg_*   in         write of expiry_ms, one cycle, no handshake
//
// Steps per item: tick ages the used frames; insert looks up the frame, scans the
// packets already in the matched frame for a duplicate (it reads one slot of the slot
// memory, then compares, and ends early on a hit) and writes; a full frame table ends
// the insert at the lookup. Query runs a rank pass over the frame table, then an expiry
// walk; pop adds a gather of the frame, then emits one packet per result as the register frees.
// Reset (i_rst_n, synchronous) empties the frame table and restores expiry_ms
// to 200; slot memory contents are left as they are.
// One item is worked at a time; i_pkt.ready is high only while idle. A result
// waits in the output register while o_res.ready is low, and a pop holds its
// next packet until the register frees up.
module rtp_frame_jitter_buffer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rfjb_pkt_if.sink                    i_pkt,
    rfjb_res_if.source                  o_res,
    input  logic                        i_cfg_we,
    input  logic [rfjb_pkg::EXP_W-1:0]  i_cfg_data
);
    import rfjb_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer: one state per step of the operation
    rfjb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pkt.valid),
        .i_operation (i_pkt.operation),
        .o_in_ready  (i_pkt.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // frame table, slot memory, walk and reorder logic, result register
    rfjb_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_rtp_stamp       (i_pkt.rtp_stamp),
        .i_seq_number      (i_pkt.seq_number),
        .i_marker_bit      (i_pkt.marker_bit),
        .i_packet_handle   (i_pkt.packet_handle),
        .i_out_ready       (o_res.ready),
        .o_out_valid       (o_res.valid),
        .o_status          (o_res.status),
        .o_available       (o_res.available),
        .o_frame_stamp_out (o_res.frame_stamp_out),
        .o_handle_out      (o_res.handle_out),
        .o_seq_out         (o_res.seq_out),
        .o_last_out        (o_res.last_out)
    );

endmodule
